// File: design/assert_macros.svh
// shared assertion macros, clocked on clk_i
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define HTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define HTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/hts_pkg.sv
`timescale 1ns / 1ps

package hts_pkg;

  localparam int COEF_FRAC_BITS = 32;

  localparam int COEF_W     = 48;
  localparam int TEMP_RAW_W = 14;
  localparam int HUM_RAW_W  = 12;
  localparam int TEMP_OUT_W = 12;
  localparam int HUM_OUT_W  = 10;

  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_STAGES = 8;

  // intermediate widths, exact for any 48-bit coefficient
  localparam int D2T_W   = COEF_W + TEMP_RAW_W + 1;   // d2 * t
  localparam int C2H_W   = COEF_W + HUM_RAW_W + 1;    // c2 * h, c3 * h
  localparam int DT_W    = 64;                         // d1 + d2 * t
  localparam int LIN_W   = C2H_W + 1;                  // c1 + c2 * h
  localparam int SQ_W    = C2H_W + HUM_RAW_W + 1;      // c3 * h * h
  localparam int RH_W    = SQ_W + 1;                   // linear humidity
  localparam int TB_W    = 64;                         // t1 - t2 * t
  localparam int HALF_W  = 32;                         // partial product split
  localparam int PP_W    = 2 * HALF_W;
  localparam int XPP_W   = PP_W + 1;                   // mixed-sign partial products
  localparam int CROSS_W = XPP_W + 1;
  localparam int WIDE_W  = 128;
  localparam int TW_W    = DT_W + 4;                   // 10 * dT
  localparam int CLAMP_W = 2 * COEF_FRAC_BITS + 7;     // 0..100 at 2F fraction bits
  localparam int H10_W   = CLAMP_W + 4;

  localparam logic signed [DT_W-1:0] TEMP_REF = 64'sd25 <<< COEF_FRAC_BITS;
  localparam logic [WIDE_W-1:0] HUM_LIMIT = 128'd100 << (2 * COEF_FRAC_BITS);

  localparam logic [TW_W-1:0] TEMP_NEG_LIMIT = TW_W'(2048);
  localparam logic [TW_W-1:0] TEMP_POS_LIMIT = TW_W'(2047);
  localparam logic [TEMP_OUT_W-1:0] TEMP_NEG_SAT = 12'h800;
  localparam logic [TEMP_OUT_W-1:0] TEMP_POS_SAT = 12'h7FF;
  localparam logic [HUM_OUT_W-1:0] HUM_MAX = 10'd1000;

  localparam logic signed [COEF_W-1:0] RST_HUM_C1  = -48'sd8790939061;
  localparam logic signed [COEF_W-1:0] RST_HUM_C2  = 48'sd157625300;
  localparam logic signed [COEF_W-1:0] RST_HUM_C3  = -48'sd6853;
  localparam logic signed [COEF_W-1:0] RST_TEMP_D1 = -48'sd170080704922;
  localparam logic signed [COEF_W-1:0] RST_TEMP_D2 = 48'sd42949673;
  localparam logic signed [COEF_W-1:0] RST_COMP_T1 = 48'sd42949673;
  localparam logic signed [COEF_W-1:0] RST_COMP_T2 = 48'sd343597;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HUM_C1  = 3'd0,
    REG_HUM_C2  = 3'd1,
    REG_HUM_C3  = 3'd2,
    REG_TEMP_D1 = 3'd3,
    REG_TEMP_D2 = 3'd4,
    REG_COMP_T1 = 3'd5,
    REG_COMP_T2 = 3'd6
  } hts_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] d1;
    logic signed [COEF_W-1:0] d2;
    logic signed [COEF_W-1:0] t1;
    logic signed [COEF_W-1:0] t2;
  } hts_coef_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;  // stage takes a new request this edge
    logic [NUM_STAGES-1:0] vld;   // stage holds a request
  } hts_ctl_t;

endpackage

// File: design/hts_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hts_pkg::hts_ctl_t ctl_o
);
  import hts_pkg::*;

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES:0]   en;
  logic [NUM_STAGES-1:0] vin;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vin = {vld_q[NUM_STAGES-2:0], in_valid_i};

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      vld_d[k] = en[k] ? vin[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.load  = en[NUM_STAGES-1:0] & vin;
  assign ctl_o.vld   = vld_q;
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  `HTS_ASSERT(a_ready_when_out_empty, !vld_q[NUM_STAGES-1] |-> in_ready_o, "input stalled with empty output stage")
  `HTS_ASSERT(a_accept_lands, in_valid_i && in_ready_o |=> vld_q[0], "accepted request missing from first stage")
  `HTS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

// File: design/hts_front.sv
`timescale 1ns / 1ps

module hts_front (
  input  logic                                      clk_i,
  input  hts_pkg::hts_ctl_t                         ctl_i,
  input  hts_pkg::hts_coef_t                        coef_i,
  input  logic [hts_pkg::TEMP_RAW_W-1:0]            raw_temperature_i,
  input  logic [hts_pkg::HUM_RAW_W-1:0]             raw_humidity_i,
  output logic signed [hts_pkg::DT_W-1:0]           a_o,
  output logic signed [hts_pkg::TB_W-1:0]           b_o,
  output logic signed [hts_pkg::RH_W-1:0]           rh_o,
  output logic [hts_pkg::TW_W-1:0]                  tw_o
);
  import hts_pkg::*;

  // stage 0: single-coefficient products
  logic signed [D2T_W-1:0] d2t_d, d2t_q, t2t_d, t2t_q;
  logic signed [C2H_W-1:0] c2h_d, c2h_q, c3h_d, c3h_q;
  logic [HUM_RAW_W-1:0]    h_q;
  // stage 1
  logic signed [DT_W-1:0]  dt_d, dt_q;
  logic signed [LIN_W-1:0] lin_d, lin_q;
  logic signed [SQ_W-1:0]  sq_d, sq_q;
  logic signed [TB_W-1:0]  tb_d, tb_q;
  // stage 2
  logic signed [DT_W-1:0]  a_d, a_q;
  logic signed [RH_W-1:0]  rh_d, rh_q;
  logic signed [TB_W-1:0]  b_q;
  logic [TW_W-1:0]         dt_ext, tw_d, tw_q;

  assign d2t_d = $signed(coef_i.d2) * $signed({1'b0, raw_temperature_i});
  assign t2t_d = $signed(coef_i.t2) * $signed({1'b0, raw_temperature_i});
  assign c2h_d = $signed(coef_i.c2) * $signed({1'b0, raw_humidity_i});
  assign c3h_d = $signed(coef_i.c3) * $signed({1'b0, raw_humidity_i});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      d2t_q <= d2t_d;
      t2t_q <= t2t_d;
      c2h_q <= c2h_d;
      c3h_q <= c3h_d;
      h_q   <= raw_humidity_i;
    end
  end

  assign dt_d  = $signed(coef_i.d1) + d2t_q;
  assign lin_d = $signed(coef_i.c1) + c2h_q;
  assign sq_d  = c3h_q * $signed({1'b0, h_q});
  assign tb_d  = $signed(coef_i.t1) - t2t_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      dt_q  <= dt_d;
      lin_q <= lin_d;
      sq_q  <= sq_d;
      tb_q  <= tb_d;
    end
  end

  // 10 * dT as shift and add
  assign dt_ext = {{(TW_W-DT_W){dt_q[DT_W-1]}}, dt_q};
  assign tw_d   = (dt_ext << 3) + (dt_ext << 1);
  assign a_d    = dt_q - TEMP_REF;
  assign rh_d   = lin_q + sq_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      a_q  <= a_d;
      b_q  <= tb_q;
      rh_q <= rh_d;
      tw_q <= tw_d;
    end
  end

  assign a_o  = a_q;
  assign b_o  = b_q;
  assign rh_o = rh_q;
  assign tw_o = tw_q;

endmodule

// File: design/hts_mult.sv
`timescale 1ns / 1ps

module hts_mult (
  input  logic                                 clk_i,
  input  hts_pkg::hts_ctl_t                    ctl_i,
  input  logic signed [hts_pkg::DT_W-1:0]      a_i,
  input  logic signed [hts_pkg::TB_W-1:0]      b_i,
  input  logic signed [hts_pkg::RH_W-1:0]      rh_i,
  input  logic [hts_pkg::TW_W-1:0]             tw_i,
  output logic [hts_pkg::WIDE_W-1:0]           rhc_o,
  output logic [hts_pkg::TEMP_OUT_W-1:0]       temp_o
);
  import hts_pkg::*;

  // stage 3: four partial products of the compensation term
  logic [PP_W-1:0]           pll_d, pll_q;
  logic signed [XPP_W-1:0]   plh_d, plh_q, phl_d, phl_q;
  logic signed [PP_W-1:0]    phh_d, phh_q;
  logic signed [RH_W-1:0]    rh_q;
  logic                      tneg_d, tneg_q;
  logic [TW_W-1:0]           tmag_d, tmag_q;
  // stage 4
  logic [CROSS_W-1:0]        cross_d, cross_q;
  logic [WIDE_W-1:0]         rh_ext, base_d, base_q;
  logic [TW_W-1:0]           tq, tq_neg;
  logic [TEMP_OUT_W-1:0]     tout_d, tout4_q;
  // stage 5
  logic [WIDE_W-1:0]         cross_ext, rhc_d, rhc_q;
  logic [TEMP_OUT_W-1:0]     tout5_q;

  assign pll_d = a_i[HALF_W-1:0] * b_i[HALF_W-1:0];
  assign plh_d = $signed({1'b0, a_i[HALF_W-1:0]}) * $signed(b_i[PP_W-1:HALF_W]);
  assign phl_d = $signed(a_i[PP_W-1:HALF_W]) * $signed({1'b0, b_i[HALF_W-1:0]});
  assign phh_d = $signed(a_i[PP_W-1:HALF_W]) * $signed(b_i[PP_W-1:HALF_W]);

  assign tneg_d = tw_i[TW_W-1];
  assign tmag_d = tneg_d ? (TW_W'(0) - tw_i) : tw_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[3]) begin
      pll_q  <= pll_d;
      plh_q  <= plh_d;
      phl_q  <= phl_d;
      phh_q  <= phh_d;
      rh_q   <= rh_i;
      tneg_q <= tneg_d;
      tmag_q <= tmag_d;
    end
  end

  // high and low products do not overlap, so they simply concatenate
  assign cross_d = CROSS_W'(plh_q) + CROSS_W'(phl_q);
  assign rh_ext  = {{(WIDE_W-RH_W){rh_q[RH_W-1]}}, rh_q};
  assign base_d  = {phh_q, pll_q} + (rh_ext << COEF_FRAC_BITS);

  // truncate toward zero on the magnitude, then saturate to 12 bits
  assign tq     = tmag_q >> COEF_FRAC_BITS;
  assign tq_neg = TW_W'(0) - tq;

  always_comb begin
    if (tneg_q) begin
      tout_d = (tq > TEMP_NEG_LIMIT) ? TEMP_NEG_SAT : tq_neg[TEMP_OUT_W-1:0];
    end else begin
      tout_d = (tq > TEMP_POS_LIMIT) ? TEMP_POS_SAT : tq[TEMP_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[4]) begin
      cross_q <= cross_d;
      base_q  <= base_d;
      tout4_q <= tout_d;
    end
  end

  assign cross_ext = {{(WIDE_W-CROSS_W){cross_q[CROSS_W-1]}}, cross_q};
  assign rhc_d     = base_q + (cross_ext << HALF_W);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[5]) begin
      rhc_q   <= rhc_d;
      tout5_q <= tout4_q;
    end
  end

  assign rhc_o  = rhc_q;
  assign temp_o = tout5_q;

endmodule

// File: design/hts_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hts_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hts_pkg::hts_ctl_t                  ctl_i,
  input  logic [hts_pkg::WIDE_W-1:0]         rhc_i,
  input  logic [hts_pkg::TEMP_OUT_W-1:0]     temp_i,
  output logic [hts_pkg::TEMP_OUT_W-1:0]     temperature_tenths_o,
  output logic [hts_pkg::HUM_OUT_W-1:0]      humidity_tenths_o
);
  import hts_pkg::*;

  logic [CLAMP_W-1:0]    clamp_d, clamp_q;
  logic [TEMP_OUT_W-1:0] temp6_q, temp7_q;
  logic [H10_W-1:0]      clamp_ext, h10;
  logic [HUM_OUT_W-1:0]  hum_d, hum_q;

  // clamp compensated humidity to 0..100
  always_comb begin
    if (rhc_i[WIDE_W-1]) begin
      clamp_d = '0;
    end else if (rhc_i > HUM_LIMIT) begin
      clamp_d = HUM_LIMIT[CLAMP_W-1:0];
    end else begin
      clamp_d = rhc_i[CLAMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[6]) begin
      clamp_q <= clamp_d;
      temp6_q <= temp_i;
    end
  end

  assign clamp_ext = {{(H10_W-CLAMP_W){1'b0}}, clamp_q};
  assign h10       = (clamp_ext << 3) + (clamp_ext << 1);
  assign hum_d     = h10[2*COEF_FRAC_BITS +: HUM_OUT_W];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[7]) begin
      hum_q   <= hum_d;
      temp7_q <= temp6_q;
    end
  end

  assign temperature_tenths_o = temp7_q;
  assign humidity_tenths_o    = hum_q;

  `HTS_ASSERT(a_neg_clamps_zero, ctl_i.load[6] && rhc_i[WIDE_W-1] |=> clamp_q == '0, "negative humidity not clamped to zero")
  `HTS_ASSERT(a_hum_in_range, ctl_i.vld[NUM_STAGES-1] |-> hum_q <= HUM_MAX, "humidity result above one hundred percent")

endmodule

// File: design/humidity_temperature_sensor_conversion.sv
`timescale 1ns / 1ps
// a request passes eight register stages in all, from the stage loaded at the edge that
//   accepts it to the output register that holds its result
// throughput: one reading per cycle while out_ready_i stays high; the 64x64 compensation
//   product is split into four partial products of 32-bit halves summed over two stages
// empty stages collapse, so a result waiting on the output stalls input only when all are full
// reset: pipeline empties and coefficients return to the RST_ defaults in hts_pkg

module humidity_temperature_sensor_conversion (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [hts_pkg::TEMP_RAW_W-1:0]        raw_temperature_i,
  input  logic [hts_pkg::HUM_RAW_W-1:0]         raw_humidity_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hts_pkg::TEMP_OUT_W-1:0] temperature_tenths_o,
  output logic [hts_pkg::HUM_OUT_W-1:0]         humidity_tenths_o,
  input  logic                                  cfg_we_i,
  input  logic [hts_pkg::REG_IDX_W-1:0]         cfg_index_i,
  input  logic [hts_pkg::COEF_W-1:0]            cfg_wdata_i
);
  import hts_pkg::*;

  hts_coef_t coef_q, coef_d;
  hts_ctl_t  ctl;

  logic signed [DT_W-1:0] a;
  logic signed [TB_W-1:0] b;
  logic signed [RH_W-1:0] rh;
  logic [TW_W-1:0]        tw;
  logic [WIDE_W-1:0]      rhc;
  logic [TEMP_OUT_W-1:0]  temp5, temp_out;

  // register write decode, index beyond the list is dropped
  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (hts_reg_e'(cfg_index_i))
        REG_HUM_C1:  coef_d.c1 = cfg_wdata_i;
        REG_HUM_C2:  coef_d.c2 = cfg_wdata_i;
        REG_HUM_C3:  coef_d.c3 = cfg_wdata_i;
        REG_TEMP_D1: coef_d.d1 = cfg_wdata_i;
        REG_TEMP_D2: coef_d.d2 = cfg_wdata_i;
        REG_COMP_T1: coef_d.t1 = cfg_wdata_i;
        REG_COMP_T2: coef_d.t2 = cfg_wdata_i;
        default:     coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.c1 <= RST_HUM_C1;
      coef_q.c2 <= RST_HUM_C2;
      coef_q.c3 <= RST_HUM_C3;
      coef_q.d1 <= RST_TEMP_D1;
      coef_q.d2 <= RST_TEMP_D2;
      coef_q.t1 <= RST_COMP_T1;
      coef_q.t2 <= RST_COMP_T2;
    end else begin
      coef_q <= coef_d;
    end
  end

  hts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  hts_front u_front (
    .clk_i             (clk_i),
    .ctl_i             (ctl),
    .coef_i            (coef_q),
    .raw_temperature_i (raw_temperature_i),
    .raw_humidity_i    (raw_humidity_i),
    .a_o               (a),
    .b_o               (b),
    .rh_o              (rh),
    .tw_o              (tw)
  );

  hts_mult u_mult (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .a_i    (a),
    .b_i    (b),
    .rh_i   (rh),
    .tw_i   (tw),
    .rhc_o  (rhc),
    .temp_o (temp5)
  );

  hts_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctl_i                (ctl),
    .rhc_i                (rhc),
    .temp_i               (temp5),
    .temperature_tenths_o (temp_out),
    .humidity_tenths_o    (humidity_tenths_o)
  );

  assign temperature_tenths_o = $signed(temp_out);

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import hts_pkg::*;

  localparam int FRAC = COEF_FRAC_BITS;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS = 100;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [TEMP_OUT_W-1:0] TEMP_LOWEST = -12'sd2048;
  localparam logic signed [TEMP_OUT_W-1:0] TEMP_HIGHEST = 12'sd2047;
  localparam logic [HUM_OUT_W-1:0] HUM_FULL = 10'd1000;
  localparam logic signed [127:0] HUM_CEIL = 128'sd100 <<< (2 * FRAC);

  localparam logic signed [COEF_W-1:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 48'sh8000_0000_0000;

  localparam hts_coef_t DEFAULT_COEFS = '{
    c1: -48'sd8790939061,
    c2: 48'sd157625300,
    c3: -48'sd6853,
    d1: -48'sd170080704922,
    d2: 48'sd42949673,
    t1: 48'sd42949673,
    t2: 48'sd343597
  };

  typedef struct packed {
    logic signed [TEMP_OUT_W-1:0] temp;
    logic [HUM_OUT_W-1:0]         hum;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [TEMP_RAW_W-1:0] raw_temperature_i = '0;
  logic [HUM_RAW_W-1:0] raw_humidity_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [TEMP_OUT_W-1:0] temperature_tenths_o;
  logic [HUM_OUT_W-1:0] humidity_tenths_o;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [COEF_W-1:0] cfg_wdata_i = '0;

  hts_coef_t coef_model = DEFAULT_COEFS;
  reading_t expected_readings[$];
  int err_count = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int coef_sets = 0;
  int cycle_count = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 16;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;

  humidity_temperature_sensor_conversion dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .raw_temperature_i    (raw_temperature_i),
    .raw_humidity_i       (raw_humidity_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .temperature_tenths_o (temperature_tenths_o),
    .humidity_tenths_o    (humidity_tenths_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // exact conversion at 128 bits, truncation toward zero on both outputs
  function automatic reading_t convert_reading(hts_coef_t k, logic [TEMP_RAW_W-1:0] t,
                                               logic [HUM_RAW_W-1:0] h);
    logic signed [127:0] tv, hv, c1, c2, c3, d1, d2, t1, t2;
    logic signed [127:0] dt, rh, rhc, tw, tq, h10;
    reading_t r;
    tv = t;
    hv = h;
    c1 = $signed(k.c1);
    c2 = $signed(k.c2);
    c3 = $signed(k.c3);
    d1 = $signed(k.d1);
    d2 = $signed(k.d2);
    t1 = $signed(k.t1);
    t2 = $signed(k.t2);
    dt = d1 + d2 * tv;
    rh = c1 + c2 * hv + c3 * hv * hv;
    rhc = (dt - (128'sd25 <<< FRAC)) * (t1 - t2 * tv) + (rh <<< FRAC);
    tw = dt * 10;
    if (tw < 0) begin
      tq = (-tw) >>> FRAC;
      r.temp = (tq > 2048) ? TEMP_LOWEST : TEMP_OUT_W'(-tq);
    end else begin
      tq = tw >>> FRAC;
      r.temp = (tq > 2047) ? TEMP_HIGHEST : TEMP_OUT_W'(tq);
    end
    if (rhc < 0) begin
      r.hum = '0;
    end else begin
      if (rhc > HUM_CEIL) rhc = HUM_CEIL;
      h10 = (rhc * 10) >>> (2 * FRAC);
      r.hum = (h10 > 1000) ? HUM_FULL : HUM_OUT_W'(h10);
    end
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(int unsigned bits);
    logic signed [COEF_W-1:0] r;
    r = COEF_W'({$urandom, $urandom});
    return r >>> (COEF_W - bits);
  endfunction

  // spread a coefficient by up to half its value either way
  function automatic logic signed [COEF_W-1:0] jitter(logic signed [COEF_W-1:0] f);
    return f + (f >>> 3) * (int'($urandom_range(8)) - 4);
  endfunction

  function automatic logic [TEMP_RAW_W-1:0] rand_temp_raw();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? '1 : '0;
    return TEMP_RAW_W'($urandom_range(16383));
  endfunction

  function automatic logic [HUM_RAW_W-1:0] rand_hum_raw();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? '1 : '0;
    return HUM_RAW_W'($urandom_range(4095));
  endfunction

  task automatic send_reading(input logic [TEMP_RAW_W-1:0] t, input logic [HUM_RAW_W-1:0] h);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= t;
    raw_humidity_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    // request accepted at this edge
    expected_readings.push_back(convert_reading(coef_model, t, h));
    readings_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_coef(input logic [REG_IDX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_HUM_C1:  coef_model.c1 = val;
      REG_HUM_C2:  coef_model.c2 = val;
      REG_HUM_C3:  coef_model.c3 = val;
      REG_TEMP_D1: coef_model.d1 = val;
      REG_TEMP_D2: coef_model.d2 = val;
      REG_COMP_T1: coef_model.t1 = val;
      REG_COMP_T2: coef_model.t2 = val;
      default: ;
    endcase
  endtask

  task automatic apply_coefs(input hts_coef_t k);
    drain();
    write_coef(REG_HUM_C1, k.c1);
    write_coef(REG_HUM_C2, k.c2);
    write_coef(REG_HUM_C3, k.c3);
    write_coef(REG_TEMP_D1, k.d1);
    write_coef(REG_TEMP_D2, k.d2);
    write_coef(REG_COMP_T1, k.t1);
    write_coef(REG_COMP_T2, k.t2);
    cfg_we_i <= 1'b0;
    coef_sets++;
  endtask

  task automatic test_reset_defaults();
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('0, '1);
    send_reading('1, '0);
    send_reading(14'd6400, 12'd1500);
    send_reading(14'd2000, 12'd3000);
  endtask

  // 10*dT just inside and just past both ends of the 12-bit field
  task automatic test_temp_limits();
    logic signed [COEF_W-1:0] offsets[5];
    hts_coef_t k;
    offsets = '{48'sd879609302220, 48'sd879609302221, -48'sd879609302220,
                -48'sd879609302221, -48'sd880038798951};
    foreach (offsets[i]) begin
      k = DEFAULT_COEFS;
      k.d2 = '0;
      k.d1 = offsets[i];
      apply_coefs(k);
      send_reading(rand_temp_raw(), rand_hum_raw());
    end
  endtask

  task automatic test_coef_extremes();
    logic signed [COEF_W-1:0] fills[3];
    fills = '{COEF_MAX, COEF_MIN, '0};
    foreach (fills[i]) begin
      apply_coefs('{c1: fills[i], c2: fills[i], c3: fills[i], d1: fills[i],
                    d2: fills[i], t1: fills[i], t2: fills[i]});
      send_reading('0, '0);
      send_reading('1, '1);
      send_reading(rand_temp_raw(), rand_hum_raw());
    end
  endtask

  task automatic test_unused_index();
    apply_coefs(DEFAULT_COEFS);
    @(posedge clk_i);
    write_coef(REG_UNUSED, '1);
    cfg_we_i <= 1'b0;
    send_reading(14'd6400, 12'd1500);
    send_reading('1, '1);
  endtask

  // output held off long enough for the pipeline to fill and push back
  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    hold_trig++;
    repeat (40) send_reading(rand_temp_raw(), rand_hum_raw());
    drain();
    send_idle_pct = 16;
  endtask

  task automatic test_random_phases();
    hts_coef_t k;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: k = DEFAULT_COEFS;
        1, 2: k = '{c1: jitter(DEFAULT_COEFS.c1), c2: jitter(DEFAULT_COEFS.c2),
                    c3: jitter(DEFAULT_COEFS.c3), d1: jitter(DEFAULT_COEFS.d1),
                    d2: jitter(DEFAULT_COEFS.d2), t1: jitter(DEFAULT_COEFS.t1),
                    t2: jitter(DEFAULT_COEFS.t2)};
        3: k = '{c1: rand_coef(48), c2: rand_coef(48), c3: rand_coef(48),
                 d1: rand_coef(48), d2: rand_coef(48), t1: rand_coef(48),
                 t2: rand_coef(48)};
        default: k = '{c1: rand_coef(36), c2: rand_coef(30), c3: rand_coef(20),
                       d1: rand_coef(40), d2: rand_coef(28), t1: rand_coef(28),
                       t2: rand_coef(22)};
      endcase
      apply_coefs(k);
      // one phase runs with no idling on either side
      send_idle_pct = (phase == 2) ? 0 : 16;
      recv_idle_pct = (phase == 2) ? 0 : 16;
      repeat (PHASE_ITEMS) send_reading(rand_temp_raw(), rand_hum_raw());
    end
    send_idle_pct = 16;
    recv_idle_pct = 16;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_temp_limits();
    test_coef_extremes();
    test_unused_index();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d readings sent, %0d results checked, %0d coefficient sets",
             readings_sent, results_checked, coef_sets);
    $display("covered defaults, temperature saturation, humidity clamps, unused index, stall");
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result checker and output ready driver
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result with none pending: temperature %0d humidity %0d",
                 $time, temperature_tenths_o, humidity_tenths_o);
        err_count++;
      end else begin
        want = expected_readings.pop_front();
        if (temperature_tenths_o !== want.temp) begin
          $display("%0t: temperature_tenths expected %0d actual %0d",
                   $time, want.temp, temperature_tenths_o);
          err_count++;
        end
        if (humidity_tenths_o !== want.hum) begin
          $display("%0t: humidity_tenths expected %0d actual %0d",
                   $time, want.hum, humidity_tenths_o);
          err_count++;
        end
        results_checked++;
      end
    end
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_readings.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
